@@ rtl/rfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational fraction ALU package
// Command codes, request and response payload types, default operand width.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int OperandBitsDefault = 16;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_SUB    = 3'd1;
   localparam logic [2:0] CMD_MUL    = 3'd2;
   localparam logic [2:0] CMD_DIV    = 3'd3;
   localparam logic [2:0] CMD_REDUCE = 3'd4;

   typedef struct packed {
      logic [2:0]          command;
      logic signed [15:0]  first_num;
      logic signed [15:0]  first_den;
      logic signed [15:0]  second_num;
      logic signed [15:0]  second_den;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0]  result_num;
      logic [29:0]         result_den;
   } rsp_payload_type;

endpackage

@@ rtl/rational_fraction_alu.sv @@
// ----------------------------------------------------------------------------
// Rational fraction ALU
// Add, subtract, multiply, divide or reduce signed fractions, with the
// result in lowest terms via a shared bit-serial divider if no numerator is 0.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_ready / req_payload) carries a command
//   and two fractions; the response channel (rsp_valid / rsp_ready /
//   rsp_payload) returns one fraction per request, 0/0 when invalid.
//   One request is worked on at a time: req_ready is high only while the
//   sequencer is idle. A finished response sits in the output register, so
//   the next request is accepted while the receiver still stalls; the
//   sequencer only waits for the output register to free up before it
//   writes the following response.
//   Every remainder or quotient comes from one restoring divider, one bit
//   per cycle, W = 2*OPERAND_BITS+2 bits wide, with a GCD test after each
//   Euclid step. Add and subtract run a second GCD over the denominators
//   first. Shortcut cases go from dispatch straight to the done state.
//   Reset (synchronous, active high) returns the sequencer to idle and
//   drops any response not yet taken.
// ----------------------------------------------------------------------------
module rational_fraction_alu
   import rfa_pkg::*;
#(
   parameter int OPERAND_BITS = OperandBitsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int N  = OPERAND_BITS;
   localparam int MW = N + 1;          // multiplier operand width
   localparam int W  = 2 * N + 2;      // working width
   localparam int CW = $clog2(W + 1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DISP = 8'b0000_0010,
      ST_MUL  = 8'b0000_0100,
      ST_RED  = 8'b0000_1000,
      ST_GCD  = 8'b0001_0000,
      ST_GDIV = 8'b0010_0000,
      ST_QDIV = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [2:0]              cmd_ff, cmd_in;
   logic signed [N-1:0]     xn_ff, xn_in, xd_ff, xd_in, yn_ff, yn_in, yd_ff, yd_in;
   logic signed [W-1:0]     num_ff, num_in, den_ff, den_in;
   logic [W-1:0]            p_ff, p_in, q_ff, q_in, ga_ff, ga_in, gb_ff, gb_in;
   logic                    neg_ff, neg_in, add_ff, add_in;
   logic [1:0]              step_ff, step_in;
   logic [W-1:0]            dq_ff, dq_in, dr_ff, dr_in, dv_ff, dv_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [W-1:0]     res_num_ff, res_num_in;
   logic [W-1:0]            res_den_ff, res_den_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_ff, rsp_in;

   // shared divider datapath
   logic [W:0]              div_shift, div_diff;
   logic                    div_ge, div_done;
   logic [W-1:0]            div_rem, div_quo;

   // shared multiplier
   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [W-1:0]     mul_p;

   // operand entry
   logic signed [N-1:0]     ex_xn, ex_xd, ex_yn, ex_yd;

   // reduce entry
   logic [W-1:0]            red_pm, red_qm;

   function automatic logic signed [N-1:0] take_op(input logic [15:0] raw);
      logic [N-1:0] v;
      v = N'(raw);
      if (v == {1'b1, {(N-1){1'b0}}}) begin
         v = v + N'(1);
      end
      return signed'(v);
   endfunction

   always_comb begin
      ex_xn = take_op(req_payload.first_num);
      ex_xd = take_op(req_payload.first_den);
      ex_yn = take_op(req_payload.second_num);
      ex_yd = take_op(req_payload.second_den);
      if (ex_xd < 0) begin
         ex_xd = -ex_xd;
         ex_xn = -ex_xn;
      end
      if (ex_yd < 0) begin
         ex_yd = -ex_yd;
         ex_yn = -ex_yn;
      end
      // subtract is add with the second numerator negated
      if (req_payload.command == CMD_SUB) begin
         ex_yn = -ex_yn;
      end
   end

   // one quotient bit a cycle
   assign div_shift = {dr_ff, dq_ff[W-1]};
   assign div_diff  = div_shift - {1'b0, dv_ff};
   assign div_ge    = div_shift >= {1'b0, dv_ff};
   assign div_rem   = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
   assign div_quo   = {dq_ff[W-2:0], div_ge};
   assign div_done  = (cnt_ff == CW'(W));

   // multiplier operand selection
   always_comb begin
      mul_a = MW'(xn_ff);
      mul_b = MW'(yn_ff);
      case (cmd_ff)
         CMD_MUL: begin
            mul_a = (step_ff == 2'd0) ? MW'(xn_ff) : MW'(xd_ff);
            mul_b = (step_ff == 2'd0) ? MW'(yn_ff) : MW'(yd_ff);
         end
         CMD_DIV: begin
            mul_a = (step_ff == 2'd0) ? MW'(xn_ff) : MW'(xd_ff);
            mul_b = (step_ff == 2'd0) ? MW'(yd_ff) : MW'(yn_ff);
         end
         default: begin
            // add: lcm = (xd/g)*yd, then xn*(yd/g) + yn*(xd/g)
            if (step_ff == 2'd0) begin
               mul_a = signed'({1'b0, p_ff[N-1:0]});
               mul_b = MW'(yd_ff);
            end else if (step_ff == 2'd1) begin
               mul_a = MW'(xn_ff);
               mul_b = signed'({1'b0, q_ff[N-1:0]});
            end else begin
               mul_a = MW'(yn_ff);
               mul_b = signed'({1'b0, p_ff[N-1:0]});
            end
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign red_pm = num_ff[W-1] ? W'(-num_ff) : W'(num_ff);
   assign red_qm = den_ff[W-1] ? W'(-den_ff) : W'(den_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      xn_in        = xn_ff;
      xd_in        = xd_ff;
      yn_in        = yn_ff;
      yd_in        = yd_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      neg_in       = neg_ff;
      add_in       = add_ff;
      step_in      = step_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      dv_in        = dv_ff;
      cnt_in       = cnt_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // release the output register once the receiver takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload.command;
               xn_in    = ex_xn;
               xd_in    = ex_xd;
               yn_in    = ex_yn;
               yd_in    = ex_yd;
               state_in = ST_DISP;
            end
         end

         ST_DISP: begin
            res_num_in = '0;
            res_den_in = '0;
            step_in    = 2'd0;
            if (cmd_ff == CMD_REDUCE) begin
               num_in   = W'(xn_ff);
               den_in   = W'(xd_ff);
               state_in = ST_RED;
            end else if (cmd_ff > CMD_REDUCE || xd_ff == '0 || yd_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               case (cmd_ff)
                  CMD_MUL: state_in = ST_MUL;
                  CMD_DIV: state_in = (yn_ff == '0) ? ST_DONE : ST_MUL;
                  default: begin
                     // pass the other operand through when one numerator is zero
                     if (xn_ff == '0) begin
                        res_num_in = W'(yn_ff);
                        res_den_in = W'(yd_ff);
                        state_in   = ST_DONE;
                     end else if (yn_ff == '0) begin
                        res_num_in = W'(xn_ff);
                        res_den_in = W'(xd_ff);
                        state_in   = ST_DONE;
                     end else begin
                        p_in     = W'(xd_ff);
                        q_in     = W'(yd_ff);
                        ga_in    = W'(xd_ff);
                        gb_in    = W'(yd_ff);
                        add_in   = 1'b1;
                        state_in = ST_GCD;
                     end
                  end
               endcase
            end
         end

         ST_MUL: begin
            step_in = step_ff + 2'd1;
            if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) begin
               if (step_ff == 2'd0) begin
                  num_in = mul_p;
               end else begin
                  den_in   = mul_p;
                  state_in = ST_RED;
               end
            end else begin
               if (step_ff == 2'd0) begin
                  den_in = mul_p;
               end else if (step_ff == 2'd1) begin
                  num_in = mul_p;
               end else begin
                  num_in   = num_ff + mul_p;
                  state_in = ST_RED;
               end
            end
         end

         ST_RED: begin
            add_in = 1'b0;
            if (den_ff == '0) begin
               res_num_in = '0;
               res_den_in = '0;
               state_in   = ST_DONE;
            end else if (num_ff == '0) begin
               res_num_in = '0;
               res_den_in = red_qm;
               state_in   = ST_DONE;
            end else begin
               neg_in   = num_ff[W-1] ^ den_ff[W-1];
               p_in     = red_pm;
               q_in     = red_qm;
               ga_in    = red_pm;
               gb_in    = red_qm;
               state_in = ST_GCD;
            end
         end

         ST_GCD: begin
            dr_in  = '0;
            cnt_in = '0;
            if (gb_ff == '0) begin
               // ga holds the gcd: divide both parts by it
               dq_in    = p_ff;
               dv_in    = ga_ff;
               step_in  = 2'd0;
               state_in = ST_QDIV;
            end else begin
               dq_in    = ga_ff;
               dv_in    = gb_ff;
               state_in = ST_GDIV;
            end
         end

         ST_GDIV: begin
            if (!div_done) begin
               dq_in  = div_quo;
               dr_in  = div_rem;
               cnt_in = cnt_ff + CW'(1);
            end else begin
               ga_in    = gb_ff;
               gb_in    = dr_ff;
               state_in = ST_GCD;
            end
         end

         ST_QDIV: begin
            if (!div_done) begin
               dq_in  = div_quo;
               dr_in  = div_rem;
               cnt_in = cnt_ff + CW'(1);
            end else if (step_ff == 2'd0) begin
               p_in    = dq_ff;
               dq_in   = q_ff;
               dr_in   = '0;
               cnt_in  = '0;
               step_in = 2'd1;
            end else begin
               q_in    = dq_ff;
               step_in = 2'd0;
               if (add_ff) begin
                  state_in = ST_MUL;
               end else begin
                  res_num_in = neg_ff ? -signed'(p_ff) : signed'(p_ff);
                  res_den_in = dq_ff;
                  state_in   = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result_num = 32'(res_num_ff);
               rsp_in.result_den = 30'(res_den_ff);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         add_ff       <= 1'b0;
         step_ff      <= 2'd0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         add_ff       <= add_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      xn_ff      <= xn_in;
      xd_ff      <= xd_in;
      yn_ff      <= yn_in;
      yd_ff      <= yd_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      neg_ff     <= neg_in;
      dq_ff      <= dq_in;
      dr_ff      <= dr_in;
      dv_ff      <= dv_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Rational fraction ALU testbench
// Drives add, subtract, multiply, divide and reduce requests through the
// valid/ready request channel under random bursts, gaps and receiver stalls,
// and checks every response against an in-bench fraction calculator.
// ----------------------------------------------------------------------------
module tb
   import rfa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OB = OperandBitsDefault;
   localparam longint OP_LIM = (64'sd1 <<< (OB - 1)) - 1;
   localparam int RANDOM_REQUESTS = 1950;
   localparam longint CYCLE_LIMIT = 64'd30000000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   rational_fraction_alu dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   req_payload_type pending_requests[$];
   rsp_payload_type expected_fractions[$];
   int  mismatch_count = 0;
   bit  long_hold      = 1'b0;
   bit  req_taken      = 1'b0;
   longint cycle_count = 0;

   // Fraction calculator: 64-bit signed working values.
   typedef struct {
      longint num;
      longint den;
   } fraction_type;

   function automatic longint take_operand(logic [15:0] raw);
      longint s;
      s = longint'($signed(raw[OB-1:0]));
      if (s < -OP_LIM) s = -OP_LIM;
      return s;
   endfunction

   function automatic fraction_type normalise(logic [15:0] n, logic [15:0] d);
      fraction_type f;
      f.num = take_operand(n);
      f.den = take_operand(d);
      if (f.den < 0) begin
         f.den = -f.den;
         f.num = -f.num;
      end
      return f;
   endfunction

   function automatic longint euclid(longint a, longint b);
      longint t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic fraction_type lowest_terms(fraction_type f);
      fraction_type r;
      longint mag;
      longint g;
      mag = (f.num < 0) ? -f.num : f.num;
      g = (mag != 0) ? euclid(mag, f.den) : 1;
      if (f.den == 0) begin
         r.num = 0;
         r.den = 0;
      end else begin
         r.num = (f.num < 0) ? -(mag / g) : mag / g;
         r.den = f.den / g;
      end
      return r;
   endfunction

   function automatic fraction_type sum_fractions(fraction_type x, fraction_type y);
      fraction_type r;
      longint l;
      if (x.num == 0) return y;
      if (y.num == 0) return x;
      l = (x.den / euclid(x.den, y.den)) * y.den;
      r.num = x.num * (l / x.den) + y.num * (l / y.den);
      r.den = l;
      return lowest_terms(r);
   endfunction

   function automatic rsp_payload_type compute_fraction(req_payload_type q);
      fraction_type x;
      fraction_type y;
      fraction_type r;
      rsp_payload_type p;
      x = normalise(q.first_num, q.first_den);
      y = normalise(q.second_num, q.second_den);
      r.num = 0;
      r.den = 0;
      if (q.command == CMD_REDUCE) begin
         if (x.den != 0) r = lowest_terms(x);
      end else if (q.command > CMD_REDUCE || x.den == 0 || y.den == 0) begin
         r.num = 0;
      end else if (q.command == CMD_ADD) begin
         r = sum_fractions(x, y);
      end else if (q.command == CMD_SUB) begin
         y.num = -y.num;
         r = sum_fractions(x, y);
      end else if (q.command == CMD_MUL) begin
         r.num = x.num * y.num;
         r.den = x.den * y.den;
         r = lowest_terms(r);
      end else if (y.num != 0) begin
         r.num = x.num * y.den;
         r.den = x.den * y.num;
         if (r.den < 0) begin
            r.den = -r.den;
            r.num = -r.num;
         end
         r = lowest_terms(r);
      end
      p.result_num = r.num[31:0];
      p.result_den = r.den[29:0];
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
               what, got, want, cycle_count);
   endtask

   // Driver: bursts of requests with random gaps; change inputs at the falling edge.
   int burst_left = 0;
   int gap_left   = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the request until it is taken
      end else begin
         if (req_valid) begin
            void'(pending_requests.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_payload <= pending_requests[0];
            req_valid   <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Track acceptance at the rising edge; queue the expected fraction.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         expected_fractions = {expected_fractions, compute_fraction(req_payload)};
      end
   end

   // Receiver stall pattern; drop rsp_ready during the long hold-off.
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 97;
      if (long_hold) begin
         rsp_ready <= 1'b0;
      end else if (stall_phase < 30) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Monitor: compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fractions.size() == 0) begin
            report_mismatch("unexpected response num", rsp_payload.result_num, 0);
         end else begin
            want = expected_fractions.pop_front();
            if (rsp_payload.result_num !== want.result_num)
               report_mismatch("result_num", rsp_payload.result_num, want.result_num);
            if (rsp_payload.result_den !== want.result_den)
               report_mismatch("result_den", rsp_payload.result_den, want.result_den);
         end
      end
   end

   // Long receiver hold-off, counted in its own process.
   initial begin
      int held;
      while (pending_requests.size() == 0 || reset) @(posedge clock);
      repeat (3000) @(posedge clock);
      long_hold = 1'b1;
      for (held = 0; held < 4000; held++) @(posedge clock);
      long_hold = 1'b0;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rational_fraction_alu verification failed");
         $finish;
      end
   end

   function automatic logic [15:0] random_operand();
      case ($urandom_range(0, 5))
         0: return 16'(($urandom_range(0, 8)) - 4);
         1: return 16'sh7FFF;
         2: return 16'sh8001;
         3: return 16'(($urandom_range(0, 60)) - 30);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_request(logic [2:0] c, logic [15:0] a, logic [15:0] b,
                              logic [15:0] d, logic [15:0] e);
      req_payload_type q;
      q.command    = c;
      q.first_num  = a;
      q.first_den  = b;
      q.second_num = d;
      q.second_den = e;
      pending_requests = {pending_requests, q};
   endtask

   initial begin
      int n;
      req_payload_type q;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every command, the listed corner cases.
      add_request(CMD_ADD,    16'sd1,     16'sd2,     16'sd1,     16'sd3);
      add_request(CMD_SUB,    16'sd1,     16'sd2,     16'sd1,     16'sd3);
      add_request(CMD_MUL,    16'sh7FFF,  16'sh7FFF,  16'sh8001,  16'sh7FFE);
      add_request(CMD_DIV,    16'sh7FFF,  16'sh8000,  16'sh8000,  16'sh7FFF);
      add_request(CMD_REDUCE, 16'sd6,     -16'sd4,    16'sd0,     16'sd0);
      add_request(CMD_REDUCE, 16'sd0,     16'sd6,     16'sd0,     16'sd0);
      add_request(CMD_REDUCE, 16'sd5,     16'sd0,     16'sd1,     16'sd1);
      add_request(CMD_ADD,    16'sd3,     16'sd0,     16'sd1,     16'sd2);
      add_request(CMD_MUL,    16'sd3,     16'sd4,     16'sd1,     16'sd0);
      add_request(CMD_ADD,    16'sd0,     16'sd9,     16'sd6,     -16'sd4);
      add_request(CMD_ADD,    16'sd6,     -16'sd4,    16'sd0,     16'sd7);
      add_request(CMD_DIV,    16'sd3,     16'sd4,     16'sd0,     16'sd5);
      add_request(CMD_DIV,    16'sd3,     16'sd4,     -16'sd5,    16'sd7);
      add_request(CMD_SUB,    16'sd1,     16'sd2,     16'sd1,     16'sd2);
      add_request(3'd5,       16'sd1,     16'sd2,     16'sd1,     16'sd2);
      add_request(3'd6,       16'sd1,     16'sd2,     16'sd1,     16'sd2);
      add_request(3'd7,       16'hFFFF,   16'hFFFF,   16'hFFFF,   16'hFFFF);
      add_request(CMD_ADD,    16'sh7FFF,  16'sh7FFE,  16'sh7FFF,  16'sh7FFD);
      add_request(CMD_SUB,    16'sh8000,  16'sh7FFF,  16'sh7FFF,  16'sh8001);
      add_request(CMD_REDUCE, 16'sh8000,  16'sh8000,  16'sd0,     16'sd0);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         q.command    = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
         q.first_num  = random_operand();
         q.first_den  = random_operand();
         q.second_num = random_operand();
         q.second_den = random_operand();
         pending_requests = {pending_requests, q};
      end

      while (pending_requests.size() != 0) @(posedge clock);
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("rational_fraction_alu verification clean");
      end else begin
         $display("rational_fraction_alu verification failed");
      end
      $finish;
   end

endmodule

@@ rational_fraction_alu.f @@
rtl/rfa_pkg.sv
rtl/rational_fraction_alu.sv
tb/tb.sv
